/* hdl/b64d_pkg.sv */
`timescale 1ns / 1ps
// Base64 decoder package: result kinds, decode modes, queue record type and
// the character-to-sextet lookup. No dependencies.
package b64d_pkg;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // decode modes
    localparam logic [1:0] MODE_DECODING = 2'd0;
    localparam logic [1:0] MODE_STOPPED  = 2'd1;
    localparam logic [1:0] MODE_ERROR    = 2'd2;

    localparam logic [7:0] CHAR_END = 8'd0;
    localparam logic [7:0] CHAR_PAD = 8'd61;   // '='
    localparam logic [7:0] CHAR_PLUS  = 8'd43; // '+'
    localparam logic [7:0] CHAR_SLASH = 8'd47; // '/'

    localparam logic [5:0] SEXT_LOWER = 6'd26;
    localparam logic [5:0] SEXT_DIGIT = 6'd52;
    localparam logic [5:0] SEXT_PLUS  = 6'd62;
    localparam logic [5:0] SEXT_SLASH = 6'd63;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    // one queued job: a decoded group or an end-of-string status
    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] word;
        logic [1:0]  nbytes;
    } t_rec;

    function automatic t_sextet sextet_of(input logic [7:0] ch);
        t_sextet r;
        r = '0;
        if (ch inside {["A":"Z"]}) begin
            r = '{ok: 1'b1, val: 6'(ch - 8'("A"))};
        end else if (ch inside {["a":"z"]}) begin
            r = '{ok: 1'b1, val: 6'(ch - 8'("a")) + SEXT_LOWER};
        end else if (ch inside {["0":"9"]}) begin
            r = '{ok: 1'b1, val: 6'(ch - 8'("0")) + SEXT_DIGIT};
        end else if (ch == CHAR_PLUS) begin
            r = '{ok: 1'b1, val: SEXT_PLUS};
        end else if (ch == CHAR_SLASH) begin
            r = '{ok: 1'b1, val: SEXT_SLASH};
        end
        return r;
    endfunction

endpackage

/* hdl/b64d_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the base64 decoder: character input
// and result output. No dependencies.
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface b64d_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic [15:0] byte_count;
    logic        run_last;

    modport source (output valid, output kind, output byte_out, output byte_count,
                    output run_last, input ready);
    modport sink   (input valid, input kind, input byte_out, input byte_count,
                    input run_last, output ready);
endinterface

/* hdl/base64_decoder.sv */
`timescale 1ns / 1ps
// Streaming base64 decoder top level. Depends on b64d_pkg, b64d_if,
// b64d_front, b64d_fifo and b64d_back.
//
// One character is taken per cycle; a character of 0 ends the string and
// yields one status result. Every fourth character of a valid group yields
// one to three data bytes. The front end classifies characters at full rate
// and posts finished groups to a four-entry queue; the back end drains
// the queue at one result per cycle, while the sink is ready, through
// a registered output. Input stalls only when that queue is full, which
// happens only while the sink holds off: no run of characters causes
// more results than it has characters, so with the sink always ready
// the queue never fills. Results pass the queue, then the output register.
module base64_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    b64d_char_if.sink    i_char,
    b64d_res_if.source   o_res
);
    import b64d_pkg::*;

    logic full;
    logic push;
    t_rec rec;
    logic head_valid;
    t_rec head;
    logic pop;

    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_char.valid),
        .i_char  (i_char.char_in),
        .i_full  (full),
        .o_ready (i_char.ready),
        .o_push  (push),
        .o_rec   (rec)
    );

    b64d_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_rec        (rec),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    b64d_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_ready      (o_res.ready),
        .o_valid      (o_res.valid),
        .o_kind       (o_res.kind),
        .o_byte       (o_res.byte_out),
        .o_count      (o_res.byte_count),
        .o_last       (o_res.run_last)
    );

endmodule

/* hdl/b64d_front.sv */
`timescale 1ns / 1ps
// Front end: takes one character per cycle unless the queue is full, tracks
// group state, pushes a record per closed group or terminator. Uses b64d_pkg.
module b64d_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_char,
    input  logic          i_full,
    output logic          o_ready,
    output logic          o_push,
    output b64d_pkg::t_rec o_rec
);
    import b64d_pkg::*;

    logic [1:0]  r_pos,  n_pos;
    logic [17:0] r_bits, n_bits;
    logic [2:0]  r_pad,  n_pad;
    logic [1:0]  r_mode, n_mode;

    t_sextet     sx;
    logic        accept;
    logic        is_pad;
    logic [5:0]  v6;
    logic [2:0]  pad_next;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign sx      = sextet_of(i_char);
    assign is_pad  = (i_char == CHAR_PAD);
    assign v6      = is_pad ? 6'd0 : sx.val;
    assign pad_next = is_pad ? r_pad + 3'd1 : r_pad;

    // character classification and group update
    always_comb begin
        n_pos  = r_pos;
        n_bits = r_bits;
        n_pad  = r_pad;
        n_mode = r_mode;
        o_push = 1'b0;
        o_rec  = '0;
        if (accept) begin
            if (i_char == CHAR_END) begin
                o_push     = 1'b1;
                o_rec.kind = ((r_mode == MODE_ERROR) ||
                              (r_mode == MODE_DECODING && r_pos != 2'd0)) ? KIND_ERR
                                                                          : KIND_OK;
                n_pos  = '0;
                n_bits = '0;
                n_pad  = '0;
                n_mode = MODE_DECODING;
            end else if (r_mode == MODE_DECODING) begin
                if (r_pos == 2'd0 && !sx.ok && !is_pad) begin
                    n_mode = MODE_STOPPED;
                end else if (!is_pad && (r_pad != 3'd0 || !sx.ok)) begin
                    n_mode = MODE_ERROR;
                end else if (r_pos != 2'd3) begin
                    n_bits = {r_bits[11:0], v6};
                    n_pos  = r_pos + 2'd1;
                    n_pad  = pad_next;
                end else if (pad_next > 3'd2) begin
                    n_pad  = pad_next;
                    n_mode = MODE_ERROR;
                end else begin
                    // group closes: three bytes less one per pad
                    o_push       = 1'b1;
                    o_rec.kind   = KIND_DATA;
                    o_rec.word   = {r_bits, v6};
                    o_rec.nbytes = 2'd3 - pad_next[1:0];
                    n_pos  = '0;
                    n_bits = '0;
                    n_pad  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_bits <= '0;
            r_pad  <= '0;
            r_mode <= MODE_DECODING;
        end else begin
            r_pos  <= n_pos;
            r_bits <= n_bits;
            r_pad  <= n_pad;
            r_mode <= n_mode;
        end
    end

endmodule

/* hdl/b64d_fifo.sv */
`timescale 1ns / 1ps
// Short record queue between front and back ends.
// Depends on b64d_pkg.
module b64d_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_rec i_rec,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_head_valid,
    output b64d_pkg::t_rec o_head
);
    import b64d_pkg::*;

    t_rec                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr, r_rd;
    logic [Q_PTR_W:0]    r_cnt;
    logic                do_pop;

    assign o_full       = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign do_pop       = i_pop && o_head_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (Q_PTR_W+1)'(i_push) - (Q_PTR_W+1)'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue push while full");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_PTR_W+1)'(Q_DEPTH)) else $error("queue count out of range");

endmodule

/* hdl/b64d_back.sv */
`timescale 1ns / 1ps
// Back end: one result per cycle unless the sink stalls, from queued records
// into an output register; keeps the saturating byte count. Uses b64d_pkg.
module b64d_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  b64d_pkg::t_rec i_head,
    output logic           o_pop,
    input  logic           i_ready,
    output logic           o_valid,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_byte,
    output logic [15:0]    o_count,
    output logic           o_last
);
    import b64d_pkg::*;

    logic                  r_valid;
    logic [1:0]            r_kind;
    logic [7:0]            r_byte;
    logic [15:0]           r_cnt_out;
    logic                  r_last;
    logic [1:0]            r_idx;
    logic [COUNT_BITS-1:0] r_count;

    logic                  load;
    logic                  is_data;
    logic                  last_byte;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [7:0]            sel_byte;

    assign load      = i_head_valid && (!r_valid || i_ready);
    assign is_data   = (i_head.kind == KIND_DATA);
    assign last_byte = (r_idx == i_head.nbytes - 2'd1);
    assign cnt_inc   = (r_count == '1) ? r_count : r_count + 1'b1;
    assign o_pop     = load && (!is_data || last_byte);

    // byte select within the 24-bit group
    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.word[23:16];
            2'd1:    sel_byte = i_head.word[15:8];
            default: sel_byte = i_head.word[7:0];
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind    <= i_head.kind;
            r_byte    <= is_data ? sel_byte : 8'd0;
            r_cnt_out <= is_data ? 16'(cnt_inc) : 16'(r_count);
            r_last    <= !is_data || last_byte;
        end
    end

    // control: output valid, byte index, running count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                if (is_data) begin
                    r_count <= cnt_inc;
                    r_idx   <= last_byte ? 2'd0 : r_idx + 2'd1;
                end else begin
                    r_count <= '0;
                    r_idx   <= '0;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_byte  = r_byte;
    assign o_count = r_cnt_out;
    assign o_last  = r_last;

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind != KIND_DATA) |-> r_last) else $error("status not last");
    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !is_data) |=> (r_count == '0)) else $error("count not cleared");

endmodule

/* dv/b64d_checker.sv */
`timescale 1ns / 1ps
// Result checker for the base64 decoder: watches the character and result
// channels, decodes accepted characters itself and compares every result.
// Depends on b64d_pkg and b64d_if.
module b64d_checker #(
    parameter int COUNT_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    b64d_char_if i_char,
    b64d_res_if  i_res,
    output int   o_pending,
    output int   o_checked,
    output int   o_fail_cnt
);
    import b64d_pkg::*;

    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] count;
        logic        last;
    } t_decoded;

    // decoder state as this checker sees it
    logic [1:0]            grp_pos;
    logic [17:0]           grp_bits;
    logic [2:0]            pad_seen;
    logic [1:0]            dec_mode;
    logic [COUNT_BITS-1:0] out_count;

    t_decoded decoded_q[$];
    t_decoded head;

    initial begin
        o_pending  = 0;
        o_checked  = 0;
        o_fail_cnt = 0;
    end

    // {valid, six-bit value} of a character in the base64 alphabet
    function automatic logic [6:0] alphabet_index(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z") return {1'b1, 6'(ch - "A")};
        if (ch >= "a" && ch <= "z") return {1'b1, 6'(ch - "a" + 26)};
        if (ch >= "0" && ch <= "9") return {1'b1, 6'(ch - "0" + 52)};
        if (ch == "+") return {1'b1, 6'd62};
        if (ch == "/") return {1'b1, 6'd63};
        return 7'd0;
    endfunction

    task automatic push_decoded(input logic [1:0] kind, input logic [7:0] data,
                                input logic last);
        decoded_q.push_back(t_decoded'{kind: kind, data: data, count: 16'(out_count),
                                       last: last});
    endtask

    task automatic clear_state();
        grp_pos   = '0;
        grp_bits  = '0;
        pad_seen  = '0;
        dec_mode  = MODE_DECODING;
        out_count = '0;
    endtask

    // expected results for one accepted character
    task automatic decode_char(input logic [7:0] ch);
        logic [6:0]  idx;
        logic [5:0]  val;
        logic [23:0] word;
        int          nbytes;
        idx = alphabet_index(ch);
        val = idx[5:0];
        if (ch == CHAR_END) begin
            push_decoded((dec_mode == MODE_ERROR ||
                          (dec_mode == MODE_DECODING && grp_pos != 0)) ?
                         KIND_ERR : KIND_OK, 8'd0, 1'b1);
            clear_state();
        end else if (dec_mode == MODE_DECODING) begin
            if (grp_pos == 0 && !idx[6] && ch != CHAR_PAD) begin
                // stop character at a group boundary
                dec_mode = MODE_STOPPED;
            end else if (ch != CHAR_PAD && (pad_seen != 0 || !idx[6])) begin
                dec_mode = MODE_ERROR;
            end else begin
                if (ch == CHAR_PAD) begin
                    pad_seen = pad_seen + 1'b1;
                    val      = '0;
                end
                if (grp_pos != 2'd3) begin
                    grp_bits = {grp_bits[11:0], val};
                    grp_pos  = grp_pos + 1'b1;
                end else if (pad_seen > 3'd2) begin
                    dec_mode = MODE_ERROR;
                end else begin
                    word   = {grp_bits, val};
                    nbytes = 3 - int'(pad_seen);
                    for (int k = 0; k < nbytes; k++) begin
                        if (out_count != '1) out_count = out_count + 1'b1;
                        push_decoded(KIND_DATA, word[23 - 8 * k -: 8], k == nbytes - 1);
                    end
                    grp_pos  = '0;
                    grp_bits = '0;
                    pad_seen = '0;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        o_fail_cnt++;
        if (o_fail_cnt <= MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            decoded_q.delete();
        end else begin
            // compare the result taken at this edge with the oldest expectation
            if (i_res.valid && i_res.ready) begin
                o_checked++;
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d byte %02h count %0d",
                                              i_res.kind, i_res.byte_out, i_res.byte_count));
                end else begin
                    head = decoded_q.pop_front();
                    if (i_res.kind !== head.kind)
                        report_mismatch($sformatf("kind %0d, want %0d",
                                                  i_res.kind, head.kind));
                    if (i_res.byte_out !== head.data)
                        report_mismatch($sformatf("byte_out %02h, want %02h",
                                                  i_res.byte_out, head.data));
                    if (i_res.byte_count !== head.count)
                        report_mismatch($sformatf("byte_count %0d, want %0d",
                                                  i_res.byte_count, head.count));
                    if (i_res.run_last !== head.last)
                        report_mismatch($sformatf("run_last %0b, want %0b",
                                                  i_res.run_last, head.last));
                end
            end
            // a request taken at this edge adds its own expectations
            if (i_char.valid && i_char.ready) decode_char(i_char.char_in);
        end
        o_pending <= decoded_q.size();
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the base64 decoder: clock, reset, character stimulus,
// sink back-pressure and the verdict. Depends on b64d_pkg, b64d_if,
// base64_decoder and b64d_checker.
module tb;
    import b64d_pkg::*;

    localparam int CNT_BITS     = 16;
    localparam int LIMIT_CYCLES = 20000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_CHARS  = 55;

    logic i_clk;
    logic i_rst_n;

    int src_idle_pct;
    int snk_idle_pct;
    int hold_token;
    int hold_seen;
    int hold_left;
    int cycle_cnt;
    int n_chars;
    int n_strings;
    int phase_start;
    int pending;
    int checked;
    int fail_cnt;

    b64d_char_if char_bus();
    b64d_res_if  res_bus();

    base64_decoder #(
        .COUNT_BITS (CNT_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_res   (res_bus)
    );

    b64d_checker #(
        .COUNT_BITS (CNT_BITS)
    ) u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char     (char_bus),
        .i_res      (res_bus),
        .o_pending  (pending),
        .o_checked  (checked),
        .o_fail_cnt (fail_cnt)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // sink: random ready, or a long hold-off when one is requested
    initial begin
        res_bus.ready = 1'b0;
        hold_seen     = 0;
        hold_left     = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_bus.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // called just after a falling edge; returns just after one
    task automatic send_char(input logic [7:0] ch);
        while ($urandom_range(99) < src_idle_pct) begin
            char_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        char_bus.valid   <= 1'b1;
        char_bus.char_in <= ch;
        do @(posedge i_clk); while (!char_bus.ready);
        n_chars++;
        if (ch == CHAR_END) n_strings++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) send_char(s[i]);
    endtask

    function automatic logic [7:0] rand_b64_char();
        int v;
        v = $urandom_range(63);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    // nonzero character outside the alphabet and not '='
    function automatic logic [7:0] rand_stop_char();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(1, 42));
            1:       return 8'($urandom_range(44, 46));
            2:       return 8'($urandom_range(91, 96));
            default: return 8'($urandom_range(123, 255));
        endcase
    endfunction

    // mostly well-formed strings, the rest short, corrupted or stopped early
    task automatic send_random_string();
        logic [7:0] str_q[$];
        int         n_grp;
        int         sel;
        int         pad_n;
        n_grp = $urandom_range(0, 3);
        sel   = $urandom_range(99);
        for (int g = 0; g < n_grp * 4; g++) str_q.push_back(rand_b64_char());
        if (n_grp > 0) begin
            pad_n = $urandom_range(0, 2);
            for (int k = 0; k < pad_n; k++) str_q[str_q.size() - 1 - k] = CHAR_PAD;
        end
        if (sel >= 70 && sel < 80) begin
            // leave a partial group before the terminator
            if (n_grp == 0) begin
                str_q.push_back(rand_b64_char());
            end else begin
                repeat ($urandom_range(1, 3)) void'(str_q.pop_back());
            end
        end else if (sel >= 80 && sel < 90) begin
            if (str_q.size() > 0)
                str_q[$urandom_range(0, str_q.size() - 1)] =
                    $urandom_range(1) ? CHAR_PAD : 8'($urandom_range(1, 255));
        end else if (sel >= 90) begin
            str_q.push_back(rand_stop_char());
            repeat ($urandom_range(0, 4)) str_q.push_back(8'($urandom_range(1, 255)));
        end
        str_q.push_back(CHAR_END);
        foreach (str_q[i]) send_char(str_q[i]);
    endtask

    task automatic run_random(input int n);
        phase_start = n_chars;
        while (n_chars - phase_start < n) send_random_string();
    endtask

    // sender goes quiet until every expected result has come
    task automatic wait_drained();
        char_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        char_bus.valid   = 1'b0;
        char_bus.char_in = CHAR_END;
        src_idle_pct     = 17;
        snk_idle_pct     = 81;
        hold_token       = 0;
        n_chars          = 0;
        n_strings        = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: three, two and one byte groups with the alphabet ends
        send_text("Az+/09A=z9==");
        send_char(CHAR_END);
        // stop character with every bit set, then an ignored character
        send_char(8'hFF);
        send_text("A");
        send_char(CHAR_END);
        // data after padding
        send_text("A=B");
        send_char(CHAR_END);
        // three pads in one group
        send_text("A===");
        send_char(CHAR_END);
        // top-bit character inside a group
        send_text("Q");
        send_char(8'h80);
        send_char(CHAR_END);

        // long sink hold-off while strings keep coming
        hold_token <= hold_token + 1;
        run_random(PHASE_CHARS);
        wait_drained();

        src_idle_pct = 81;
        snk_idle_pct = 17;
        run_random(PHASE_CHARS);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(PHASE_CHARS);
        char_bus.valid <= 1'b0;

        wait_drained();
        repeat (20) @(negedge i_clk);

        $display("Covered %0d strings (%0d characters) under three idle mixes,", n_strings,
                 n_chars);
        $display("a long sink hold-off and padding, stop and error cases; %0d results compared.",
                 checked);
        if (fail_cnt == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
